/* hw/rtl/rv32i_instruction_decoder_unit_defines.svh */
// assertion macros shared by the decoder checker
`ifndef RV32I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RVID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RVID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rvid_pkg.sv */
package rvid_pkg;

  // major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_ALUI   = 7'h13;
  localparam logic [6:0] OPC_ALUR   = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // operation codes as seen on the result
  localparam logic [5:0] OP_ILLEGAL = 6'd0;
  localparam logic [5:0] OP_LUI     = 6'd1;
  localparam logic [5:0] OP_AUIPC   = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_JALR    = 6'd4;
  localparam logic [5:0] OP_BEQ     = 6'd5;
  localparam logic [5:0] OP_BNE     = 6'd6;
  localparam logic [5:0] OP_BLT     = 6'd7;
  localparam logic [5:0] OP_BGE     = 6'd8;
  localparam logic [5:0] OP_BLTU    = 6'd9;
  localparam logic [5:0] OP_BGEU    = 6'd10;
  localparam logic [5:0] OP_LB      = 6'd11;
  localparam logic [5:0] OP_LH      = 6'd12;
  localparam logic [5:0] OP_LW      = 6'd13;
  localparam logic [5:0] OP_LBU     = 6'd14;
  localparam logic [5:0] OP_LHU     = 6'd15;
  localparam logic [5:0] OP_SB      = 6'd16;
  localparam logic [5:0] OP_SH      = 6'd17;
  localparam logic [5:0] OP_SW      = 6'd18;
  localparam logic [5:0] OP_ADDI    = 6'd19;
  localparam logic [5:0] OP_SLTI    = 6'd20;
  localparam logic [5:0] OP_SLTIU   = 6'd21;
  localparam logic [5:0] OP_XORI    = 6'd22;
  localparam logic [5:0] OP_ORI     = 6'd23;
  localparam logic [5:0] OP_ANDI    = 6'd24;
  localparam logic [5:0] OP_SLLI    = 6'd25;
  localparam logic [5:0] OP_SRLI    = 6'd26;
  localparam logic [5:0] OP_SRAI    = 6'd27;
  localparam logic [5:0] OP_ADD     = 6'd28;
  localparam logic [5:0] OP_SUB     = 6'd29;
  localparam logic [5:0] OP_SLL     = 6'd30;
  localparam logic [5:0] OP_SLT     = 6'd31;
  localparam logic [5:0] OP_SLTU    = 6'd32;
  localparam logic [5:0] OP_XOR     = 6'd33;
  localparam logic [5:0] OP_SRL     = 6'd34;
  localparam logic [5:0] OP_SRA     = 6'd35;
  localparam logic [5:0] OP_OR      = 6'd36;
  localparam logic [5:0] OP_AND     = 6'd37;
  localparam logic [5:0] OP_CSRRW   = 6'd38;
  localparam logic [5:0] OP_CSRRS   = 6'd39;
  localparam logic [5:0] OP_CSRRC   = 6'd40;
  localparam logic [5:0] OP_CSRRWI  = 6'd41;
  localparam logic [5:0] OP_CSRRSI  = 6'd42;
  localparam logic [5:0] OP_CSRRCI  = 6'd43;
  localparam logic [5:0] OP_ECALL   = 6'd44;
  localparam logic [5:0] OP_EBREAK  = 6'd45;

  typedef enum logic [2:0] {
    IMM_NONE,
    IMM_I,
    IMM_S,
    IMM_B,
    IMM_U,
    IMM_J,
    IMM_SHAMT
  } imm_fmt_e;

  typedef struct packed {
    logic [31:0] instruction_word;
    logic [31:0] pc_address;
  } req_t;

  typedef struct packed {
    logic [5:0]         operation;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        target_address;
    logic [11:0]        csr_number;
  } rsp_t;

  // after classification
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] pc;
    logic [5:0]  op;
    imm_fmt_e    fmt;
    logic        tgt_en;
    logic        csr_en;
  } cls_t;

  // after immediate generation
  typedef struct packed {
    logic [5:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] pc;
    logic        tgt_en;
    logic [11:0] csr;
  } imm_t;

endpackage

/* hw/rtl/rvid_classify.sv */
module rvid_classify (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  rvid_pkg::req_t     req_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rvid_pkg::cls_t     cls_o
);

  logic           valid_q;
  rvid_pkg::cls_t cls_d, cls_q;
  logic [31:0]    w;
  logic [2:0]     f3;
  logic [6:0]     f7;

  function automatic logic [5:0] branch_op(input logic [2:0] f);
    case (f)
      3'd0:    return rvid_pkg::OP_BEQ;
      3'd1:    return rvid_pkg::OP_BNE;
      3'd4:    return rvid_pkg::OP_BLT;
      3'd5:    return rvid_pkg::OP_BGE;
      3'd6:    return rvid_pkg::OP_BLTU;
      3'd7:    return rvid_pkg::OP_BGEU;
      default: return rvid_pkg::OP_ILLEGAL;
    endcase
  endfunction

  function automatic logic [5:0] load_op(input logic [2:0] f);
    case (f)
      3'd0:    return rvid_pkg::OP_LB;
      3'd1:    return rvid_pkg::OP_LH;
      3'd2:    return rvid_pkg::OP_LW;
      3'd4:    return rvid_pkg::OP_LBU;
      3'd5:    return rvid_pkg::OP_LHU;
      default: return rvid_pkg::OP_ILLEGAL;
    endcase
  endfunction

  function automatic logic [5:0] store_op(input logic [2:0] f);
    case (f)
      3'd0:    return rvid_pkg::OP_SB;
      3'd1:    return rvid_pkg::OP_SH;
      3'd2:    return rvid_pkg::OP_SW;
      default: return rvid_pkg::OP_ILLEGAL;
    endcase
  endfunction

  // shifts are handled separately
  function automatic logic [5:0] alui_op(input logic [2:0] f);
    case (f)
      3'd0:    return rvid_pkg::OP_ADDI;
      3'd2:    return rvid_pkg::OP_SLTI;
      3'd3:    return rvid_pkg::OP_SLTIU;
      3'd4:    return rvid_pkg::OP_XORI;
      3'd6:    return rvid_pkg::OP_ORI;
      3'd7:    return rvid_pkg::OP_ANDI;
      default: return rvid_pkg::OP_ILLEGAL;
    endcase
  endfunction

  function automatic logic [5:0] alur_op(input logic [2:0] f);
    case (f)
      3'd0:    return rvid_pkg::OP_ADD;
      3'd1:    return rvid_pkg::OP_SLL;
      3'd2:    return rvid_pkg::OP_SLT;
      3'd3:    return rvid_pkg::OP_SLTU;
      3'd4:    return rvid_pkg::OP_XOR;
      3'd5:    return rvid_pkg::OP_SRL;
      3'd6:    return rvid_pkg::OP_OR;
      default: return rvid_pkg::OP_AND;
    endcase
  endfunction

  function automatic logic [5:0] csr_op(input logic [2:0] f);
    case (f)
      3'd1:    return rvid_pkg::OP_CSRRW;
      3'd2:    return rvid_pkg::OP_CSRRS;
      3'd3:    return rvid_pkg::OP_CSRRC;
      3'd5:    return rvid_pkg::OP_CSRRWI;
      3'd6:    return rvid_pkg::OP_CSRRSI;
      3'd7:    return rvid_pkg::OP_CSRRCI;
      default: return rvid_pkg::OP_ILLEGAL;
    endcase
  endfunction

  assign w  = req_i.instruction_word;
  assign f3 = w[14:12];
  assign f7 = w[31:25];

  always_comb begin
    cls_d.word   = w;
    cls_d.pc     = req_i.pc_address;
    cls_d.op     = rvid_pkg::OP_ILLEGAL;
    cls_d.fmt    = rvid_pkg::IMM_NONE;
    cls_d.tgt_en = 1'b0;
    cls_d.csr_en = 1'b0;
    if (w == rvid_pkg::WORD_ECALL) begin
      cls_d.op = rvid_pkg::OP_ECALL;
    end else if (w == rvid_pkg::WORD_EBREAK) begin
      cls_d.op = rvid_pkg::OP_EBREAK;
    end else begin
      case (w[6:0])
        rvid_pkg::OPC_LUI: begin
          cls_d.op  = rvid_pkg::OP_LUI;
          cls_d.fmt = rvid_pkg::IMM_U;
        end
        rvid_pkg::OPC_AUIPC: begin
          cls_d.op  = rvid_pkg::OP_AUIPC;
          cls_d.fmt = rvid_pkg::IMM_U;
        end
        rvid_pkg::OPC_JAL: begin
          cls_d.op     = rvid_pkg::OP_JAL;
          cls_d.fmt    = rvid_pkg::IMM_J;
          cls_d.tgt_en = 1'b1;
        end
        rvid_pkg::OPC_JALR: begin
          if (f3 == 3'd0) begin
            cls_d.op  = rvid_pkg::OP_JALR;
            cls_d.fmt = rvid_pkg::IMM_I;
          end
        end
        rvid_pkg::OPC_BRANCH: begin
          cls_d.op = branch_op(f3);
          if (cls_d.op != rvid_pkg::OP_ILLEGAL) begin
            cls_d.fmt    = rvid_pkg::IMM_B;
            cls_d.tgt_en = 1'b1;
          end
        end
        rvid_pkg::OPC_LOAD: begin
          cls_d.op = load_op(f3);
          if (cls_d.op != rvid_pkg::OP_ILLEGAL) cls_d.fmt = rvid_pkg::IMM_I;
        end
        rvid_pkg::OPC_STORE: begin
          cls_d.op = store_op(f3);
          if (cls_d.op != rvid_pkg::OP_ILLEGAL) cls_d.fmt = rvid_pkg::IMM_S;
        end
        rvid_pkg::OPC_ALUI: begin
          if (f3 == 3'd1) begin
            if (f7 == rvid_pkg::F7_BASE) begin
              cls_d.op  = rvid_pkg::OP_SLLI;
              cls_d.fmt = rvid_pkg::IMM_SHAMT;
            end
          end else if (f3 == 3'd5) begin
            if (f7 == rvid_pkg::F7_BASE) begin
              cls_d.op  = rvid_pkg::OP_SRLI;
              cls_d.fmt = rvid_pkg::IMM_SHAMT;
            end else if (f7 == rvid_pkg::F7_ALT) begin
              cls_d.op  = rvid_pkg::OP_SRAI;
              cls_d.fmt = rvid_pkg::IMM_SHAMT;
            end
          end else begin
            cls_d.op  = alui_op(f3);
            cls_d.fmt = rvid_pkg::IMM_I;
          end
        end
        rvid_pkg::OPC_ALUR: begin
          if (f7 == rvid_pkg::F7_BASE) begin
            cls_d.op = alur_op(f3);
          end else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd0) begin
            cls_d.op = rvid_pkg::OP_SUB;
          end else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd5) begin
            cls_d.op = rvid_pkg::OP_SRA;
          end
        end
        rvid_pkg::OPC_SYSTEM: begin
          cls_d.op = csr_op(f3);
          if (cls_d.op != rvid_pkg::OP_ILLEGAL) begin
            cls_d.fmt    = rvid_pkg::IMM_I;
            cls_d.csr_en = 1'b1;
          end
        end
        default: begin
          cls_d.op = rvid_pkg::OP_ILLEGAL;
        end
      endcase
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cls_q <= cls_d;
    end
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_q;

endmodule

/* hw/rtl/rvid_immgen.sv */
module rvid_immgen (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rvid_pkg::cls_t cls_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rvid_pkg::imm_t imm_o
);

  logic           valid_q;
  rvid_pkg::imm_t imm_d, imm_q;
  logic [31:0]    w;

  assign w = cls_i.word;

  always_comb begin
    imm_d.op     = cls_i.op;
    imm_d.rd     = w[11:7];
    imm_d.rs1    = w[19:15];
    imm_d.rs2    = w[24:20];
    imm_d.pc     = cls_i.pc;
    imm_d.tgt_en = cls_i.tgt_en;
    imm_d.csr    = cls_i.csr_en ? w[31:20] : 12'd0;
    case (cls_i.fmt)
      rvid_pkg::IMM_I:     imm_d.imm = {{20{w[31]}}, w[31:20]};
      rvid_pkg::IMM_S:     imm_d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      rvid_pkg::IMM_B:     imm_d.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      rvid_pkg::IMM_U:     imm_d.imm = {w[31:12], 12'd0};
      rvid_pkg::IMM_J:     imm_d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      rvid_pkg::IMM_SHAMT: imm_d.imm = {27'd0, w[24:20]};
      default:             imm_d.imm = 32'd0;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      imm_q <= imm_d;
    end
  end

  assign valid_o = valid_q;
  assign imm_o   = imm_q;

endmodule

/* hw/rtl/rvid_target.sv */
module rvid_target (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rvid_pkg::imm_t imm_i,
  output logic           valid_o,
  input  logic           ready_i,
  output rvid_pkg::rsp_t rsp_o
);

  logic           valid_q;
  rvid_pkg::rsp_t rsp_d, rsp_q;

  always_comb begin
    rsp_d.operation      = imm_i.op;
    rsp_d.dest_reg       = imm_i.rd;
    rsp_d.src1_reg       = imm_i.rs1;
    rsp_d.src2_reg       = imm_i.rs2;
    rsp_d.immediate      = imm_i.imm;
    rsp_d.csr_number     = imm_i.csr;
    // wraps modulo 2^32
    rsp_d.target_address = imm_i.tgt_en ? (imm_i.pc + imm_i.imm) : 32'd0;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

/* hw/rtl/rv32i_instruction_decoder_unit.sv */
// rv32i instruction decoder
// request channel: in_valid_i / in_ready_o carry the instruction word and
// its fetch address (in_req_i). response channel: out_valid_o / out_ready_i
// carry the operation code, register fields, immediate, branch or jal
// target and csr number (out_rsp_o). operation 0 marks an illegal word.
// three register stages: classify (opcode, funct3, funct7), immediate
// generation, then the 32-bit target add feeding the output register.
// an accepted request moves through the classify, immediate and target
// registers in that order; out_valid_o comes from the target register.
// throughput is one request per cycle while the receiver does not stall;
// every stage takes a new request in the same cycle its own contents leave.
// when out_ready_i is low the output holds and the stall ripples back one
// stage per occupied register; up to three requests are held, none are
// lost or repeated.
// reset clears all stage valid bits; the block accepts requests in the
// first cycle after reset is released.
module rv32i_instruction_decoder_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rvid_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rvid_pkg::rsp_t out_rsp_o
);

  logic           cls_valid, cls_ready;
  rvid_pkg::cls_t cls;
  logic           imm_valid, imm_ready;
  rvid_pkg::imm_t imm;

  rvid_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req_i),
    .valid_o (cls_valid),
    .ready_i (cls_ready),
    .cls_o   (cls)
  );

  rvid_immgen u_immgen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cls_valid),
    .ready_o (cls_ready),
    .cls_i   (cls),
    .valid_o (imm_valid),
    .ready_i (imm_ready),
    .imm_o   (imm)
  );

  rvid_target u_target (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (imm_valid),
    .ready_o (imm_ready),
    .imm_i   (imm),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_rsp_o)
  );

endmodule

/* hw/rtl/rvid_checker.sv */
`include "rv32i_instruction_decoder_unit_defines.svh"

module rvid_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input rvid_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rvid_pkg::rsp_t out_rsp_o
);

  logic is_tgt_op, is_csr_op, is_illegal;

  assign is_tgt_op = out_rsp_o.operation == rvid_pkg::OP_JAL
                  || (out_rsp_o.operation >= rvid_pkg::OP_BEQ
                      && out_rsp_o.operation <= rvid_pkg::OP_BGEU);
  assign is_csr_op = out_rsp_o.operation >= rvid_pkg::OP_CSRRW
                  && out_rsp_o.operation <= rvid_pkg::OP_CSRRCI;
  assign is_illegal = out_rsp_o.operation == rvid_pkg::OP_ILLEGAL;

  // a waiting request holds
  `RVID_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_req_i), "waiting request changed")

  // a stalled response holds
  `RVID_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o), "stalled response changed")

  // illegal words carry no immediate, target or csr number
  `RVID_ASSERT_IMP(a_illegal_zero, clk_i, rst_ni, out_valid_o && is_illegal, out_rsp_o.immediate == 0 && out_rsp_o.target_address == 0 && out_rsp_o.csr_number == 0, "illegal response with payload")

  // target only for branches and jal
  `RVID_ASSERT_IMP(a_target_zero, clk_i, rst_ni, out_valid_o && !is_tgt_op, out_rsp_o.target_address == 0, "target on non-control op")

  // csr number only for csr operations
  `RVID_ASSERT_IMP(a_csr_zero, clk_i, rst_ni, out_valid_o && !is_csr_op, out_rsp_o.csr_number == 0, "csr number on non-csr op")

endmodule

bind rv32i_instruction_decoder_unit rvid_checker u_rvid_checker (.*);

/* tb/rv32i_instruction_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module rv32i_instruction_decoder_unit_tb;

  localparam int unsigned RANDOM_PER_PHASE = 610;
  localparam int unsigned HOLD_CYCLES      = 60;
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam int unsigned CYCLE_LIMIT      = 500000;

  class decode_scoreboard;
    rvid_pkg::rsp_t pending_decodes[$];
    int unsigned    mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function rvid_pkg::rsp_t decode_instruction(logic [31:0] word, logic [31:0] pc);
      rvid_pkg::rsp_t     r;
      rvid_pkg::imm_fmt_e fmt;
      logic [2:0] f3;
      logic [6:0] f7;
      logic     csr_en;
      r           = '0;
      fmt         = rvid_pkg::IMM_NONE;
      csr_en      = 1'b0;
      f3          = word[14:12];
      f7          = word[31:25];
      r.operation = rvid_pkg::OP_ILLEGAL;
      r.dest_reg  = word[11:7];
      r.src1_reg  = word[19:15];
      r.src2_reg  = word[24:20];
      // the exact system words win over the opcode table
      if (word == rvid_pkg::WORD_ECALL) begin
        r.operation = rvid_pkg::OP_ECALL;
      end else if (word == rvid_pkg::WORD_EBREAK) begin
        r.operation = rvid_pkg::OP_EBREAK;
      end else begin
        case (word[6:0])
          rvid_pkg::OPC_LUI: begin
            r.operation = rvid_pkg::OP_LUI;
            fmt = rvid_pkg::IMM_U;
          end
          rvid_pkg::OPC_AUIPC: begin
            r.operation = rvid_pkg::OP_AUIPC;
            fmt = rvid_pkg::IMM_U;
          end
          rvid_pkg::OPC_JAL: begin
            r.operation = rvid_pkg::OP_JAL;
            fmt = rvid_pkg::IMM_J;
          end
          rvid_pkg::OPC_JALR: begin
            if (f3 == 3'd0) r.operation = rvid_pkg::OP_JALR;
            fmt = rvid_pkg::IMM_I;
          end
          rvid_pkg::OPC_BRANCH: begin
            fmt = rvid_pkg::IMM_B;
            case (f3)
              3'd0: r.operation = rvid_pkg::OP_BEQ;
              3'd1: r.operation = rvid_pkg::OP_BNE;
              3'd4: r.operation = rvid_pkg::OP_BLT;
              3'd5: r.operation = rvid_pkg::OP_BGE;
              3'd6: r.operation = rvid_pkg::OP_BLTU;
              3'd7: r.operation = rvid_pkg::OP_BGEU;
              default: r.operation = rvid_pkg::OP_ILLEGAL;
            endcase
          end
          rvid_pkg::OPC_LOAD: begin
            fmt = rvid_pkg::IMM_I;
            case (f3)
              3'd0: r.operation = rvid_pkg::OP_LB;
              3'd1: r.operation = rvid_pkg::OP_LH;
              3'd2: r.operation = rvid_pkg::OP_LW;
              3'd4: r.operation = rvid_pkg::OP_LBU;
              3'd5: r.operation = rvid_pkg::OP_LHU;
              default: r.operation = rvid_pkg::OP_ILLEGAL;
            endcase
          end
          rvid_pkg::OPC_STORE: begin
            fmt = rvid_pkg::IMM_S;
            case (f3)
              3'd0: r.operation = rvid_pkg::OP_SB;
              3'd1: r.operation = rvid_pkg::OP_SH;
              3'd2: r.operation = rvid_pkg::OP_SW;
              default: r.operation = rvid_pkg::OP_ILLEGAL;
            endcase
          end
          rvid_pkg::OPC_ALUI: begin
            fmt = rvid_pkg::IMM_I;
            case (f3)
              3'd0: r.operation = rvid_pkg::OP_ADDI;
              3'd1: begin
                fmt = rvid_pkg::IMM_SHAMT;
                if (f7 == rvid_pkg::F7_BASE) r.operation = rvid_pkg::OP_SLLI;
              end
              3'd2: r.operation = rvid_pkg::OP_SLTI;
              3'd3: r.operation = rvid_pkg::OP_SLTIU;
              3'd4: r.operation = rvid_pkg::OP_XORI;
              3'd5: begin
                fmt = rvid_pkg::IMM_SHAMT;
                if (f7 == rvid_pkg::F7_BASE) r.operation = rvid_pkg::OP_SRLI;
                else if (f7 == rvid_pkg::F7_ALT) r.operation = rvid_pkg::OP_SRAI;
              end
              3'd6: r.operation = rvid_pkg::OP_ORI;
              default: r.operation = rvid_pkg::OP_ANDI;
            endcase
          end
          rvid_pkg::OPC_ALUR: begin
            if (f7 == rvid_pkg::F7_BASE) begin
              case (f3)
                3'd0: r.operation = rvid_pkg::OP_ADD;
                3'd1: r.operation = rvid_pkg::OP_SLL;
                3'd2: r.operation = rvid_pkg::OP_SLT;
                3'd3: r.operation = rvid_pkg::OP_SLTU;
                3'd4: r.operation = rvid_pkg::OP_XOR;
                3'd5: r.operation = rvid_pkg::OP_SRL;
                3'd6: r.operation = rvid_pkg::OP_OR;
                default: r.operation = rvid_pkg::OP_AND;
              endcase
            end else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd0) begin
              r.operation = rvid_pkg::OP_SUB;
            end else if (f7 == rvid_pkg::F7_ALT && f3 == 3'd5) begin
              r.operation = rvid_pkg::OP_SRA;
            end
          end
          rvid_pkg::OPC_SYSTEM: begin
            fmt    = rvid_pkg::IMM_I;
            csr_en = 1'b1;
            case (f3)
              3'd1: r.operation = rvid_pkg::OP_CSRRW;
              3'd2: r.operation = rvid_pkg::OP_CSRRS;
              3'd3: r.operation = rvid_pkg::OP_CSRRC;
              3'd5: r.operation = rvid_pkg::OP_CSRRWI;
              3'd6: r.operation = rvid_pkg::OP_CSRRSI;
              3'd7: r.operation = rvid_pkg::OP_CSRRCI;
              default: r.operation = rvid_pkg::OP_ILLEGAL;
            endcase
          end
          default: r.operation = rvid_pkg::OP_ILLEGAL;
        endcase
      end
      // an illegal word carries only the raw register fields
      if (r.operation == rvid_pkg::OP_ILLEGAL) begin
        fmt    = rvid_pkg::IMM_NONE;
        csr_en = 1'b0;
      end
      case (fmt)
        rvid_pkg::IMM_I:     r.immediate = {{20{word[31]}}, word[31:20]};
        rvid_pkg::IMM_S:     r.immediate = {{20{word[31]}}, word[31:25], word[11:7]};
        rvid_pkg::IMM_B:     r.immediate = {{19{word[31]}}, word[31], word[7], word[30:25],
                                            word[11:8], 1'b0};
        rvid_pkg::IMM_U:     r.immediate = {word[31:12], 12'h000};
        rvid_pkg::IMM_J:     r.immediate = {{11{word[31]}}, word[31], word[19:12], word[20],
                                            word[30:21], 1'b0};
        rvid_pkg::IMM_SHAMT: r.immediate = {27'd0, word[24:20]};
        default:             r.immediate = '0;
      endcase
      if (fmt == rvid_pkg::IMM_B || fmt == rvid_pkg::IMM_J) begin
        r.target_address = pc + r.immediate;
      end
      if (csr_en) r.csr_number = word[31:20];
      return r;
    endfunction

    function void note_request(rvid_pkg::req_t req);
      pending_decodes.push_back(decode_instruction(req.instruction_word, req.pc_address));
    endfunction

    function void compare_field(string name, logic [31:0] want_val, logic [31:0] got_val);
      if (want_val !== got_val) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_val, got_val);
        mismatch_count++;
      end
    endfunction

    function void check_response(rvid_pkg::rsp_t rsp);
      rvid_pkg::rsp_t want;
      if (pending_decodes.size() == 0) begin
        $display("%0t: response with no request pending, expected none, actual %h",
                 $time, rsp);
        mismatch_count++;
        return;
      end
      want = pending_decodes.pop_front();
      compare_field("operation", 32'(want.operation), 32'(rsp.operation));
      compare_field("dest_reg", 32'(want.dest_reg), 32'(rsp.dest_reg));
      compare_field("src1_reg", 32'(want.src1_reg), 32'(rsp.src1_reg));
      compare_field("src2_reg", 32'(want.src2_reg), 32'(rsp.src2_reg));
      compare_field("immediate", want.immediate, rsp.immediate);
      compare_field("target_address", want.target_address, rsp.target_address);
      compare_field("csr_number", 32'(want.csr_number), 32'(rsp.csr_number));
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  rvid_pkg::req_t in_req    = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rvid_pkg::rsp_t out_rsp;

  int unsigned sender_idle_pct   = 33;
  int unsigned receiver_idle_pct = 73;
  logic        hold_receiver     = 1'b0;
  logic        hold_done         = 1'b0;
  int unsigned cycle_count       = 0;

  decode_scoreboard decode_sb;

  rv32i_instruction_decoder_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // everything is stable at the falling edge, so handshakes are sampled there
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) decode_sb.note_request(in_req);
      if (out_valid && out_ready) decode_sb.check_response(out_rsp);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_receiver && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // fills in the opcode and function fields of an operation, rest stays random; ecall and ebreak give their fixed words
  function automatic logic [31:0] encode_operation(logic [5:0] op, logic [31:0] raw);
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    opc = raw[6:0];
    f3  = raw[14:12];
    f7  = raw[31:25];
    case (op)
      rvid_pkg::OP_LUI:    opc = rvid_pkg::OPC_LUI;
      rvid_pkg::OP_AUIPC:  opc = rvid_pkg::OPC_AUIPC;
      rvid_pkg::OP_JAL:    opc = rvid_pkg::OPC_JAL;
      rvid_pkg::OP_JALR:   begin opc = rvid_pkg::OPC_JALR;   f3 = 3'd0; end
      rvid_pkg::OP_BEQ:    begin opc = rvid_pkg::OPC_BRANCH; f3 = 3'd0; end
      rvid_pkg::OP_BNE:    begin opc = rvid_pkg::OPC_BRANCH; f3 = 3'd1; end
      rvid_pkg::OP_BLT:    begin opc = rvid_pkg::OPC_BRANCH; f3 = 3'd4; end
      rvid_pkg::OP_BGE:    begin opc = rvid_pkg::OPC_BRANCH; f3 = 3'd5; end
      rvid_pkg::OP_BLTU:   begin opc = rvid_pkg::OPC_BRANCH; f3 = 3'd6; end
      rvid_pkg::OP_BGEU:   begin opc = rvid_pkg::OPC_BRANCH; f3 = 3'd7; end
      rvid_pkg::OP_LB:     begin opc = rvid_pkg::OPC_LOAD;   f3 = 3'd0; end
      rvid_pkg::OP_LH:     begin opc = rvid_pkg::OPC_LOAD;   f3 = 3'd1; end
      rvid_pkg::OP_LW:     begin opc = rvid_pkg::OPC_LOAD;   f3 = 3'd2; end
      rvid_pkg::OP_LBU:    begin opc = rvid_pkg::OPC_LOAD;   f3 = 3'd4; end
      rvid_pkg::OP_LHU:    begin opc = rvid_pkg::OPC_LOAD;   f3 = 3'd5; end
      rvid_pkg::OP_SB:     begin opc = rvid_pkg::OPC_STORE;  f3 = 3'd0; end
      rvid_pkg::OP_SH:     begin opc = rvid_pkg::OPC_STORE;  f3 = 3'd1; end
      rvid_pkg::OP_SW:     begin opc = rvid_pkg::OPC_STORE;  f3 = 3'd2; end
      rvid_pkg::OP_ADDI:   begin opc = rvid_pkg::OPC_ALUI;   f3 = 3'd0; end
      rvid_pkg::OP_SLTI:   begin opc = rvid_pkg::OPC_ALUI;   f3 = 3'd2; end
      rvid_pkg::OP_SLTIU:  begin opc = rvid_pkg::OPC_ALUI;   f3 = 3'd3; end
      rvid_pkg::OP_XORI:   begin opc = rvid_pkg::OPC_ALUI;   f3 = 3'd4; end
      rvid_pkg::OP_ORI:    begin opc = rvid_pkg::OPC_ALUI;   f3 = 3'd6; end
      rvid_pkg::OP_ANDI:   begin opc = rvid_pkg::OPC_ALUI;   f3 = 3'd7; end
      rvid_pkg::OP_SLLI:   begin
        opc = rvid_pkg::OPC_ALUI; f3 = 3'd1; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_SRLI:   begin
        opc = rvid_pkg::OPC_ALUI; f3 = 3'd5; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_SRAI:   begin
        opc = rvid_pkg::OPC_ALUI; f3 = 3'd5; f7 = rvid_pkg::F7_ALT;
      end
      rvid_pkg::OP_ADD:    begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd0; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_SUB:    begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd0; f7 = rvid_pkg::F7_ALT;
      end
      rvid_pkg::OP_SLL:    begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd1; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_SLT:    begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd2; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_SLTU:   begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd3; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_XOR:    begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd4; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_SRL:    begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd5; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_SRA:    begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd5; f7 = rvid_pkg::F7_ALT;
      end
      rvid_pkg::OP_OR:     begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd6; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_AND:    begin
        opc = rvid_pkg::OPC_ALUR; f3 = 3'd7; f7 = rvid_pkg::F7_BASE;
      end
      rvid_pkg::OP_CSRRW:  begin opc = rvid_pkg::OPC_SYSTEM; f3 = 3'd1; end
      rvid_pkg::OP_CSRRS:  begin opc = rvid_pkg::OPC_SYSTEM; f3 = 3'd2; end
      rvid_pkg::OP_CSRRC:  begin opc = rvid_pkg::OPC_SYSTEM; f3 = 3'd3; end
      rvid_pkg::OP_CSRRWI: begin opc = rvid_pkg::OPC_SYSTEM; f3 = 3'd5; end
      rvid_pkg::OP_CSRRSI: begin opc = rvid_pkg::OPC_SYSTEM; f3 = 3'd6; end
      rvid_pkg::OP_CSRRCI: begin opc = rvid_pkg::OPC_SYSTEM; f3 = 3'd7; end
      rvid_pkg::OP_ECALL:  return rvid_pkg::WORD_ECALL;
      rvid_pkg::OP_EBREAK: return rvid_pkg::WORD_EBREAK;
      default:             opc = raw[6:0];
    endcase
    return {f7, raw[24:15], f3, raw[11:7], opc};
  endfunction

  function automatic rvid_pkg::req_t random_request();
    rvid_pkg::req_t r;
    logic [31:0]    raw;
    logic [5:0]     op;
    int unsigned    pick;
    raw  = $urandom;
    pick = $urandom_range(99);
    op   = 6'($urandom_range(1, 45));
    if (pick < 80) begin
      r.instruction_word = encode_operation(op, raw);
    end else if (pick < 92) begin
      // known major opcode with arbitrary function fields
      case ($urandom_range(9))
        0: raw[6:0] = rvid_pkg::OPC_LUI;
        1: raw[6:0] = rvid_pkg::OPC_AUIPC;
        2: raw[6:0] = rvid_pkg::OPC_JAL;
        3: raw[6:0] = rvid_pkg::OPC_JALR;
        4: raw[6:0] = rvid_pkg::OPC_BRANCH;
        5: raw[6:0] = rvid_pkg::OPC_LOAD;
        6: raw[6:0] = rvid_pkg::OPC_STORE;
        7: raw[6:0] = rvid_pkg::OPC_ALUI;
        8: raw[6:0] = rvid_pkg::OPC_ALUR;
        default: raw[6:0] = rvid_pkg::OPC_SYSTEM;
      endcase
      r.instruction_word = raw;
    end else if (pick < 96) begin
      // one bit away from ecall or ebreak
      r.instruction_word = (pick[0] ? rvid_pkg::WORD_ECALL : rvid_pkg::WORD_EBREAK)
                         ^ (32'd1 << $urandom_range(31));
    end else begin
      r.instruction_word = raw;
    end
    pick = $urandom_range(9);
    if (pick == 0) r.pc_address = {24'hffffff, 8'($urandom)};
    else if (pick == 1) r.pc_address = $urandom_range(255);
    else r.pc_address = $urandom;
    return r;
  endfunction

  task automatic drive_request(input rvid_pkg::req_t req);
    logic taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (decode_sb.pending_decodes.size() != 0);
  endtask

  initial begin
    decode_sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words: field extremes, address wrap and the illegal corners
    drive_request({32'hffff_ffb7, 32'h0000_0000});  // lui, all ones upper
    drive_request({32'h0000_0017, 32'hffff_ffff});  // auipc, zero immediate
    drive_request({32'h8000_006f, 32'h0000_0010});  // jal, most negative offset wraps
    drive_request({32'h7fff_f0ef, 32'hffff_fff0});  // jal, largest offset wraps
    drive_request({32'hfff0_8067, 32'h1234_5678});  // jalr
    drive_request({32'h0000_1067, 32'h0000_0000});  // jalr with nonzero funct3
    drive_request({32'h8000_0063, 32'h0000_0000});  // beq backwards below zero
    drive_request({32'h0000_2063, 32'h0000_0100});  // branch, undefined funct3
    drive_request({32'h7e00_7fe3, 32'hffff_fffc});  // bgeu, largest offset
    drive_request({32'h8000_2003, 32'h0000_0000});  // lw
    drive_request({32'h0000_3003, 32'h0000_0000});  // load, undefined funct3
    drive_request({32'hfe00_afa3, 32'h0000_0000});  // sw, all ones immediate
    drive_request({32'h0000_3023, 32'h0000_0000});  // store, undefined funct3
    drive_request({32'h01f0_1013, 32'h0000_0000});  // slli by 31
    drive_request({32'h4000_1013, 32'h0000_0000});  // slli with alternate funct7
    drive_request({32'h41f0_5013, 32'h0000_0000});  // srai by 31
    drive_request({32'h0200_5013, 32'h0000_0000});  // shift right, bad funct7
    drive_request({32'h4000_0033, 32'h0000_0000});  // sub
    drive_request({32'h4000_5033, 32'h0000_0000});  // sra
    drive_request({32'h4000_1033, 32'h0000_0000});  // sll with alternate funct7
    drive_request({32'hffff_bff3, 32'h0000_0000});  // csrrc, all ones
    drive_request({32'h3405_5073, 32'h0000_0000});  // csrrwi
    drive_request({32'h0000_4073, 32'h0000_0000});  // system funct3 4
    drive_request({32'h0000_00f3, 32'h0000_0000});  // system funct3 0, not exact
    drive_request({rvid_pkg::WORD_ECALL, 32'hffff_ffff});
    drive_request({rvid_pkg::WORD_EBREAK, 32'h0000_0000});
    drive_request({32'h0ff0_000f, 32'h0000_0000});  // fence
    drive_request({32'h0000_0000, 32'h0000_0000});
    drive_request({32'hffff_ffff, 32'hffff_ffff});
    wait_for_drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 33; receiver_idle_pct = 73; end
        1: begin sender_idle_pct = 73; receiver_idle_pct = 33; end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          hold_receiver     = 1'b1;  // back-pressure until the pipeline is full
        end
      endcase
      repeat (RANDOM_PER_PHASE) drive_request(random_request());
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decode_sb.mismatch_count == 0 && decode_sb.pending_decodes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
